/* rtl/nat_pkg.sv */
// Shared types and constants for the node address table with aging.
package nat_pkg;

  localparam logic [2:0] MODE_TAG_HELLO    = 3'd0;
  localparam logic [2:0] MODE_READER_HELLO = 3'd1;
  localparam logic [2:0] MODE_TAG_PONG     = 3'd2;
  localparam logic [2:0] MODE_ID_BY_ADDR   = 3'd3;
  localparam logic [2:0] MODE_ADDR_BY_ID   = 3'd4;
  localparam logic [2:0] MODE_SWEEP        = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [15:0] NOT_FOUND_ID = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] node_id;
    logic [15:0] short_addr;
    logic [15:0] router_addr_1;
    logic [15:0] router_addr_2;
    logic [15:0] router_addr_3;
    logic [7:0]  dist_in_1;
    logic [7:0]  dist_in_2;
    logic [7:0]  dist_in_3;
    logic [31:0] now_ms;
  } nat_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [15:0] result_addr;
    logic [15:0] reader_id_1;
    logic [15:0] reader_id_2;
    logic [15:0] reader_id_3;
    logic [7:0]  dist_out_1;
    logic [7:0]  dist_out_2;
    logic [7:0]  dist_out_3;
    logic [5:0]  live_count;
    logic        last;
  } nat_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture the request and clear the scan state.
    logic rscan;      // Examine one reader entry.
    logic tscan;      // Examine one tag entry.
    logic commit;     // Apply the request's write and emit its single result.
    logic emit_cnt;   // Emit the final sweep count item.
  } nat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rdone;
    logic tdone;
  } nat_sts_t;

endpackage

/* rtl/node_address_table_with_aging_top.sv */
// Top level of the node address table with aging.
// A tag pong request scans the reader table and then the tag table, a reader hello scans
// only the reader table and skips the tag scan, and the others scan only the tag table.
// One request is handled at a time; the tables are scanned one entry per cycle.
// Sweep results appear during the tag scan, at most one per cycle (one per live, unaged entry), then the count item.
// Synchronous active-low reset empties both tables and sets timeout_ms to 15000.
// Results are strobed for one cycle; the receiver cannot stall.
module node_address_table_with_aging_top
  import nat_pkg::*;
#(
  parameter int TAG_ENTRIES    = 16,
  parameter int READER_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  nat_in_t     in_req,
  output logic        out_strobe,
  output nat_out_t    out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_timeout_ms
);

  logic [31:0] timeout_r;
  nat_cmd_t    cmd;
  nat_sts_t    sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 32'd15000;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_timeout_ms;
    end
  end

  nat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_req.mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  nat_dp #(
    .TAG_ENTRIES    (TAG_ENTRIES),
    .READER_ENTRIES (READER_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .timeout_ms (timeout_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_strobe),
    .out_item   (out_result)
  );

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("request loaded while busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rscan, cmd.tscan, cmd.commit, cmd.emit_cnt}))
    else $error("controller issued more than one command");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.last |=> !out_strobe)
    else $error("result after final item");

endmodule

/* rtl/nat_ctrl.sv */
// Controller state machine that sequences each request's table scans.
module nat_ctrl
  import nat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] mode,
  input  nat_sts_t   sts,
  output nat_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RSCAN  = 6'b000010,
    S_TSCAN  = 6'b000100,
    S_COMMIT = 6'b001000,
    S_COUNT  = 6'b010000,
    S_GAP    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   sweep_r, sweep_nxt;

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          sweep_nxt = (mode == MODE_SWEEP);
          if (mode == MODE_READER_HELLO || mode == MODE_TAG_PONG) begin
            state_nxt = S_RSCAN;
          end else if (mode == MODE_TAG_HELLO || mode == MODE_ID_BY_ADDR ||
                       mode == MODE_ADDR_BY_ID || mode == MODE_SWEEP) begin
            state_nxt = S_TSCAN;
          end
        end
      end
      S_RSCAN: begin
        cmd.rscan = 1'b1;
        if (sts.rdone) begin
          state_nxt = S_TSCAN;
        end
      end
      S_TSCAN: begin
        cmd.tscan = 1'b1;
        if (sts.tdone) begin
          state_nxt = sweep_r ? S_COUNT : S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_GAP;
      end
      S_COUNT: begin
        cmd.emit_cnt = 1'b1;
        state_nxt    = S_GAP;
      end
      S_GAP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sweep_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

endmodule

/* rtl/nat_dp.sv */
// Datapath holding both tables and scanning them one entry per cycle.
module nat_dp
  import nat_pkg::*;
#(
  parameter int TAG_ENTRIES    = 16,
  parameter int READER_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  nat_in_t     in_req,
  input  logic [31:0] timeout_ms,
  input  nat_cmd_t    cmd,
  output nat_sts_t    sts,
  output logic        out_valid,
  output nat_out_t    out_item
);

  localparam int TW = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
  localparam int RW = (READER_ENTRIES > 1) ? $clog2(READER_ENTRIES) : 1;
  localparam int TCW = $clog2(TAG_ENTRIES + 1);
  localparam int RCW = $clog2(READER_ENTRIES + 1);

  logic [TAG_ENTRIES-1:0]    tag_alive_r;
  logic [15:0]               tag_ident_r   [TAG_ENTRIES];
  logic [15:0]               tag_short_r   [TAG_ENTRIES];
  logic [47:0]               tag_readers_r [TAG_ENTRIES];
  logic [23:0]               tag_dists_r   [TAG_ENTRIES];
  logic [31:0]               tag_stamp_r   [TAG_ENTRIES];
  logic [READER_ENTRIES-1:0] reader_alive_r;
  logic [31:0]               reader_entry_r [READER_ENTRIES];

  nat_in_t        req_r;
  logic [RCW-1:0] rcnt_r;
  logic [TCW-1:0] tcnt_r;
  logic [5:0]     live_r;
  logic [15:0]    rid_r [3];
  logic           rsel_r [3];
  logic           found_r;
  logic [TW-1:0]  hit_r;
  logic           free_ok_r;
  logic [TW-1:0]  free_r;
  logic           rfound_r;
  logic [RW-1:0]  rhit_r;
  logic           rfree_ok_r;
  logic [RW-1:0]  rfree_r;
  logic           out_valid_r;
  nat_out_t       out_r;
  logic           out_valid_nxt;
  nat_out_t       out_nxt;

  logic [TW-1:0] ti;
  logic [RW-1:0] ri;
  logic          t_al, r_al, tmatch, rmatch, aged;
  logic [15:0]   r_id, r_ad;
  logic [31:0]   age;

  assign ti   = tcnt_r[TW-1:0];
  assign ri   = rcnt_r[RW-1:0];
  assign t_al = tag_alive_r[ti];
  assign r_al = reader_alive_r[ri];
  assign r_id = reader_entry_r[ri][15:0];
  assign r_ad = reader_entry_r[ri][31:16];
  assign age  = req_r.now_ms - tag_stamp_r[ti];
  assign aged = age > timeout_ms;

  always_comb begin
    tmatch = 1'b0;
    case (req_r.mode)
      MODE_TAG_HELLO:  tmatch = (tag_ident_r[ti] == req_r.node_id) ||
                                (tag_short_r[ti] == req_r.short_addr);
      MODE_TAG_PONG:   tmatch = (tag_short_r[ti] == req_r.short_addr);
      MODE_ID_BY_ADDR: tmatch = (tag_short_r[ti] == req_r.short_addr) &&
                                (req_r.short_addr != 16'd0);
      MODE_ADDR_BY_ID: tmatch = (tag_ident_r[ti] == req_r.node_id);
      default:         tmatch = 1'b0;
    endcase
    rmatch = (r_id == req_r.node_id) || (r_ad == req_r.short_addr);
  end

  assign sts.rdone = (rcnt_r == RCW'(READER_ENTRIES - 1));
  assign sts.tdone = (tcnt_r == TCW'(TAG_ENTRIES - 1));

  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    if (cmd.tscan && req_r.mode == MODE_SWEEP && t_al && !aged) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{status: ST_OK, result_id: tag_ident_r[ti],
                        result_addr: tag_short_r[ti],
                        reader_id_1: tag_readers_r[ti][15:0],
                        reader_id_2: tag_readers_r[ti][31:16],
                        reader_id_3: tag_readers_r[ti][47:32],
                        dist_out_1: tag_dists_r[ti][7:0],
                        dist_out_2: tag_dists_r[ti][15:8],
                        dist_out_3: tag_dists_r[ti][23:16],
                        live_count: 6'd0, last: 1'b0};
    end
    if (cmd.emit_cnt) begin
      out_valid_nxt      = 1'b1;
      out_nxt.live_count = live_r;
      out_nxt.last       = 1'b1;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_nxt.last  = 1'b1;
      case (req_r.mode)
        MODE_TAG_HELLO: begin
          if (!found_r && !free_ok_r) begin
            out_nxt.status = ST_FULL;
          end
        end
        MODE_READER_HELLO: begin
          if (!rfound_r && !rfree_ok_r) begin
            out_nxt.status = ST_FULL;
          end
        end
        MODE_TAG_PONG: begin
          if (!found_r) begin
            out_nxt.status = ST_MISS;
          end
        end
        MODE_ID_BY_ADDR: begin
          if (found_r) begin
            out_nxt.result_id   = tag_ident_r[hit_r];
            out_nxt.result_addr = req_r.short_addr;
          end else begin
            out_nxt.status    = ST_MISS;
            out_nxt.result_id = NOT_FOUND_ID;
          end
        end
        MODE_ADDR_BY_ID: begin
          if (found_r) begin
            out_nxt.result_id   = req_r.node_id;
            out_nxt.result_addr = tag_short_r[hit_r];
          end else begin
            out_nxt.status    = ST_MISS;
            out_nxt.result_id = NOT_FOUND_ID;
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_alive_r    <= '0;
      reader_alive_r <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < TAG_ENTRIES; i++) begin
        tag_ident_r[i]   <= '0;
        tag_short_r[i]   <= '0;
        tag_readers_r[i] <= '0;
        tag_dists_r[i]   <= '0;
        tag_stamp_r[i]   <= '0;
      end
      for (int i = 0; i < READER_ENTRIES; i++) begin
        reader_entry_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      if (cmd.load) begin
        req_r      <= in_req;
        rcnt_r     <= '0;
        tcnt_r     <= '0;
        live_r     <= '0;
        found_r    <= 1'b0;
        free_ok_r  <= 1'b0;
        rfound_r   <= 1'b0;
        rfree_ok_r <= 1'b0;
        hit_r      <= '0;
        free_r     <= '0;
        rhit_r     <= '0;
        rfree_r    <= '0;
        for (int k = 0; k < 3; k++) begin
          rid_r[k]  <= NOT_FOUND_ID;
          rsel_r[k] <= 1'b0;
        end
      end
      if (cmd.rscan) begin
        if (!sts.rdone) begin
          rcnt_r <= rcnt_r + RCW'(1);
        end
        if (r_al) begin
          if (req_r.router_addr_1 != 16'd0 && r_ad == req_r.router_addr_1 &&
              !rsel_r[0]) begin
            rid_r[0]  <= r_id;
            rsel_r[0] <= 1'b1;
          end
          if (req_r.router_addr_2 != 16'd0 && r_ad == req_r.router_addr_2 &&
              !rsel_r[1]) begin
            rid_r[1]  <= r_id;
            rsel_r[1] <= 1'b1;
          end
          if (req_r.router_addr_3 != 16'd0 && r_ad == req_r.router_addr_3 &&
              !rsel_r[2]) begin
            rid_r[2]  <= r_id;
            rsel_r[2] <= 1'b1;
          end
          if (rmatch && !rfound_r) begin
            rfound_r <= 1'b1;
            rhit_r   <= ri;
          end
        end else if (!rfree_ok_r) begin
          rfree_ok_r <= 1'b1;
          rfree_r    <= ri;
        end
      end
      if (cmd.tscan && req_r.mode == MODE_READER_HELLO) begin
        tcnt_r <= TCW'(TAG_ENTRIES - 1);
      end else if (cmd.tscan) begin
        if (!sts.tdone) begin
          tcnt_r <= tcnt_r + TCW'(1);
        end
        if (req_r.mode == MODE_SWEEP) begin
          if (!t_al || aged) begin
            tag_alive_r[ti] <= 1'b0;
          end else begin
            live_r <= live_r + 6'd1;
          end
        end else if (t_al) begin
          if (tmatch && !found_r) begin
            found_r <= 1'b1;
            hit_r   <= ti;
          end
        end else if (!free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r    <= ti;
        end
      end
      if (cmd.commit) begin
        case (req_r.mode)
          MODE_TAG_HELLO: begin
            if (found_r) begin
              if (tag_ident_r[hit_r] == req_r.node_id) begin
                tag_short_r[hit_r] <= req_r.short_addr;
              end else begin
                tag_ident_r[hit_r] <= req_r.node_id;
              end
              tag_stamp_r[hit_r] <= req_r.now_ms;
            end else if (free_ok_r) begin
              tag_alive_r[free_r] <= 1'b1;
              tag_ident_r[free_r] <= req_r.node_id;
              tag_short_r[free_r] <= req_r.short_addr;
              tag_stamp_r[free_r] <= req_r.now_ms;
            end
          end
          MODE_READER_HELLO: begin
            if (rfound_r) begin
              reader_entry_r[rhit_r] <= {req_r.short_addr, req_r.node_id};
            end else if (rfree_ok_r) begin
              reader_alive_r[rfree_r] <= 1'b1;
              reader_entry_r[rfree_r] <= {req_r.short_addr, req_r.node_id};
            end
          end
          MODE_TAG_PONG: begin
            if (found_r) begin
              tag_readers_r[hit_r] <= {rid_r[2], rid_r[1], rid_r[0]};
              tag_dists_r[hit_r]   <= {req_r.dist_in_3, req_r.dist_in_2,
                                       req_r.dist_in_1};
              tag_stamp_r[hit_r]   <= req_r.now_ms;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
